>>> design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the timed task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SCHED = 2'd1,
        MODE_PROC  = 2'd2,
        MODE_CLR   = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic CFG_CLK_PERIOD  = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    localparam int CFG_DATA_W     = 20;
    localparam int CLK_PERIOD_W   = 10;
    localparam int HALF_PERIOD_W  = 20;
    localparam int SEC_W          = 32;
    localparam int TIME_W         = 64;
    localparam int DELAY_W        = 32;
    localparam int FIELD_W        = 16;
    localparam int QCOUNT_W       = 5;
    localparam int IN_DATA_W      = 64;
    localparam int OUT_DATA_W     = 88;

    localparam logic [CLK_PERIOD_W-1:0]  CLK_PERIOD_RST  = 10'd1;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 20'd500000;
    localparam logic [TIME_W-1:0]        USEC_PER_SEC    = 64'd1000000;
    localparam logic [TIME_W-1:0]        USEC_PER_MSEC   = 64'd1000;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_EXP,
        S_EXEC
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic exp;
        logic exec;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> design/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer for one item: accept, multiply, sum, expiry, execute.
// ----------------------------------------------------------------------------
module tts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  tts_pkg::t_sts i_sts,
    output tts_pkg::t_cmd o_cmd
);
    import tts_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_EXP;
            S_EXP:  n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_MUL:  o_cmd.mul = 1'b1;
            S_SUM:  o_cmd.sum = 1'b1;
            S_EXP:  o_cmd.exp = 1'b1;
            S_EXEC: o_cmd.exec = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_load_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL))
        else $error("accepted beat did not start the multiply step");

    a_exec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_IDLE))
        else $error("execute did not return to idle");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !(o_cmd.mul || o_cmd.sum || o_cmd.exp || o_cmd.exec))
        else $error("ready raised while an item is in work");

endmodule

>>> design/tts_dp.sv
// ----------------------------------------------------------------------------
// tts_dp
// Time keeping, expiry arithmetic, sorted queue cells and output register.
// ----------------------------------------------------------------------------
module tts_dp #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_WIDTH     = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                        i_mode,
    input  logic [tts_pkg::IN_DATA_W-1:0]     i_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [tts_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  tts_pkg::t_cmd                     i_cmd,
    output tts_pkg::t_sts                     o_sts
);
    import tts_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [CLK_PERIOD_W-1:0]  r_clk_per;
    logic [HALF_PERIOD_W-1:0] r_half_per;

    // time state
    logic [SEC_W-1:0] r_sec;
    logic             r_half;

    // latched item
    t_mode                    r_mode;
    logic [COUNTER_WIDTH-1:0] r_cnt;
    logic [TAG_WIDTH-1:0]     r_tag;
    logic [DELAY_W-1:0]       r_delay;

    // arithmetic pipeline
    logic [TIME_W-1:0] r_p_sec;
    logic [TIME_W-1:0] r_p_cnt;
    logic [TIME_W-1:0] r_p_dly;
    logic [TIME_W-1:0] r_half_add;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_exp;
    logic              r_due;

    // queue cells
    logic [TIME_W-1:0]    r_exp_q [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] r_tag_q [QUEUE_DEPTH];
    logic [TIME_W-1:0]    n_exp_q [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] n_tag_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic do_ins;
    logic do_pop;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_per  <= CLK_PERIOD_RST;
            r_half_per <= HALF_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLK_PERIOD:  r_clk_per  <= i_cfg_data[CLK_PERIOD_W-1:0];
                CFG_HALF_PERIOD: r_half_per <= i_cfg_data[HALF_PERIOD_W-1:0];
                default: r_clk_per <= r_clk_per;
            endcase
        end
    end

    // half-second time state, updated as the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= '0;
            r_half <= 1'b0;
        end else if (i_cmd.load) begin
            case (t_mode'(i_mode))
                MODE_TICK: begin
                    r_half <= !r_half;
                    if (r_half) begin
                        r_sec <= r_sec + 1'b1;
                    end
                end
                MODE_CLR: begin
                    r_sec  <= '0;
                    r_half <= 1'b0;
                end
                default: r_half <= r_half;
            endcase
        end
    end

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_cnt   <= COUNTER_WIDTH'(i_data[FIELD_W-1:0]);
            r_tag   <= TAG_WIDTH'(i_data[2*FIELD_W-1:FIELD_W]);
            r_delay <= i_data[2*FIELD_W+DELAY_W-1:2*FIELD_W];
        end
    end

    // products, then time sum, then expiry and due check
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_sec    <= TIME_W'(r_sec) * USEC_PER_SEC;
            r_p_cnt    <= TIME_W'(r_cnt) * TIME_W'(r_clk_per);
            r_p_dly    <= TIME_W'(r_delay) * USEC_PER_MSEC;
            r_half_add <= r_half ? TIME_W'(r_half_per) : '0;
        end
        if (i_cmd.sum) begin
            r_now <= r_p_sec + r_p_cnt + r_half_add;
        end
        if (i_cmd.exp) begin
            r_exp <= r_now + r_p_dly;
            r_due <= (r_count != '0) && (r_now >= r_exp_q[0]);
        end
    end

    assign do_ins = i_cmd.exec && (r_mode == MODE_SCHED)
                    && (r_count < CNT_W'(QUEUE_DEPTH));
    assign do_pop = i_cmd.exec && (r_mode == MODE_PROC) && r_due;

    // per-cell compare against the new expiry
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_exp_q[i] > r_exp);
        end
    end

    // cell next values: shift right on insert, left on pop
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic place;
        logic prev_gt;
        logic [TIME_W-1:0]    left_exp;
        logic [TAG_WIDTH-1:0] left_tag;
        logic [TIME_W-1:0]    right_exp;
        logic [TAG_WIDTH-1:0] right_tag;
        if (g == 0) begin : g_first
            assign prev_gt  = 1'b0;
            assign left_exp = r_exp;
            assign left_tag = r_tag;
        end else begin : g_rest
            assign prev_gt  = gt[g-1];
            assign left_exp = r_exp_q[g-1];
            assign left_tag = r_tag_q[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_exp = r_exp_q[g];
            assign right_tag = r_tag_q[g];
        end else begin : g_mid
            assign right_exp = r_exp_q[g+1];
            assign right_tag = r_tag_q[g+1];
        end
        assign place = (CNT_W'(g) == r_count) || gt[g];

        always_comb begin
            n_exp_q[g] = r_exp_q[g];
            n_tag_q[g] = r_tag_q[g];
            if (do_ins && place) begin
                n_exp_q[g] = prev_gt ? left_exp : r_exp;
                n_tag_q[g] = prev_gt ? left_tag : r_tag;
            end else if (do_pop) begin
                n_exp_q[g] = right_exp;
                n_tag_q[g] = right_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            r_exp_q[g] <= n_exp_q[g];
            r_tag_q[g] <= n_tag_q[g];
        end
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {1'b0, r_now, QCOUNT_W'(n_count), do_ins,
                           do_pop ? FIELD_W'(r_tag_q[0]) : {FIELD_W{1'b0}}, do_pop};
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink the queue");

    a_ins_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) && (QUEUE_DEPTH > 1) |-> (r_exp_q[0] <= r_exp_q[1]))
        else $error("queue head out of order");

endmodule

>>> design/timed_task_scheduler.sv
// Each item runs through the controller sequence of accept, multiply, time sum,
// expiry add and queue execute; the execute step waits until the output is free.
// A new item is taken only once the previous one has left that sequence.
// A new beat is taken while the previous result still waits on the output.
// Reset (synchronous, active low) clears time, queue count and config to defaults.
// ----------------------------------------------------------------------------
// timed_task_scheduler
// Half-second system time with a sorted timer event queue.
// ----------------------------------------------------------------------------
module timed_task_scheduler #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_WIDTH     = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // counter_now, task_tag, delay_ms
    input  logic [tts_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // mode
    input  logic [1:0]                        i_s_tuser,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // fired, fired_tag, accepted, queue_count, time_count, zero pad
    output logic [tts_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import tts_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tts_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_WIDTH     (TAG_WIDTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mode     (i_s_tuser),
        .i_data     (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule
